// File: sv/ssm_pkg.sv
// ssm_pkg: shared types, constants and helpers of the stream statistics monitor.
// Used by every module of the block; depends on nothing.
package ssm_pkg;

    // Accumulator and result widths
    localparam int ACCUM_W = 48;
    localparam int VAL_W   = 48;
    localparam int OPA_W   = ACCUM_W + 1;      // sum of two accumulators
    localparam int OPB_W   = 17;               // scale factors up to 100000
    localparam int NUM_W   = OPA_W + OPB_W;    // dividend bits
    localparam int DEN_W   = ACCUM_W + 4;      // accumulator times ten
    localparam int CNT_W   = $clog2(NUM_W + 1);

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = $clog2(Q_DEPTH);

    // Reset values of the schedule
    localparam logic [15:0] INTERVAL_RST = 16'd1000;
    localparam logic [39:0] NEXT_DUE_RST = 40'd1000;

    // Input opcodes
    localparam logic [2:0] OP_FRAME = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_PRES  = 3'd2;
    localparam logic [2:0] OP_DROP  = 3'd3;
    localparam logic [2:0] OP_RTT   = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    // Snapshot quantity codes
    localparam logic [4:0] Q_FPS_TOTAL = 5'd0;
    localparam logic [4:0] Q_FPS_RX    = 5'd1;
    localparam logic [4:0] Q_FPS_DEC   = 5'd2;
    localparam logic [4:0] Q_FPS_PRES  = 5'd3;
    localparam logic [4:0] Q_BITRATE   = 5'd4;
    localparam logic [4:0] Q_LOSS      = 5'd5;
    localparam logic [4:0] Q_JITTER    = 5'd6;
    localparam logic [4:0] Q_HL_MIN    = 5'd7;
    localparam logic [4:0] Q_HL_MAX    = 5'd8;
    localparam logic [4:0] Q_HL_AVG    = 5'd9;
    localparam logic [4:0] Q_REASM     = 5'd10;
    localparam logic [4:0] Q_DECODE    = 5'd11;
    localparam logic [4:0] Q_PRESENT   = 5'd12;
    localparam logic [4:0] Q_QDELAY    = 5'd13;
    localparam logic [4:0] Q_HAS_HL    = 5'd14;
    localparam logic [4:0] Q_DROPS     = 5'd15;
    localparam logic [4:0] Q_RTT       = 5'd16;
    localparam logic [4:0] Q_RTT_VAR   = 5'd17;

    // Accumulator slots
    localparam int A_RX     = 0;
    localparam int A_BYTES  = 1;
    localparam int A_MISS   = 2;
    localparam int A_HSUM   = 3;
    localparam int A_HCNT   = 4;
    localparam int A_REASM  = 5;
    localparam int A_DEC    = 6;
    localparam int A_DECUS  = 7;
    localparam int A_PRES   = 8;
    localparam int A_PRESUS = 9;
    localparam int A_QDLY   = 10;
    localparam int A_DROPS  = 11;
    localparam int N_ACC    = 12;

    typedef enum logic [2:0] {
        K_FRAME = 3'd0,
        K_DEC   = 3'd1,
        K_PRES  = 3'd2,
        K_DROP  = 3'd3,
        K_RTT   = 3'd4,
        K_TICK  = 3'd5
    } t_kind;

    // Classified event: d0/d1 carry the per-kind operands
    typedef struct packed {
        t_kind        kind;
        logic [30:0]  fn;
        logic [15:0]  hl;
        logic [39:0]  d0;
        logic [31:0]  d1;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPER,
        ST_WAIT,
        ST_PUT,
        ST_FIN
    } t_state;

    // Add with saturation at the accumulator width
    function automatic logic [ACCUM_W-1:0] sat_add(input logic [ACCUM_W-1:0] acc,
                                                   input logic [31:0]        v);
        logic [ACCUM_W:0] sum;
        sum = {1'b0, acc} + (ACCUM_W+1)'(v);
        return sum[ACCUM_W] ? '1 : sum[ACCUM_W-1:0];
    endfunction

endpackage

// File: sv/ssm_front.sv
// ssm_front: accepts input beats and classifies them into queue commands.
// Depends on ssm_pkg.
module ssm_front (
    input  logic                 i_valid,
    input  logic                 i_full,
    input  logic [2:0]           i_opcode,
    input  logic [30:0]          i_frame_number,
    input  logic signed [31:0]   i_byte_count,
    input  logic [15:0]          i_host_latency_tenths_ms,
    input  logic [31:0]          i_reassembly_us,
    input  logic [31:0]          i_duration_us,
    input  logic [31:0]          i_queue_delay_us,
    input  logic [31:0]          i_rtt_ms,
    input  logic [31:0]          i_rtt_variance_ms,
    input  logic [39:0]          i_now_ms,
    output logic                 o_stall,
    output logic                 o_push,
    output ssm_pkg::t_cmd        o_cmd
);

    logic known;

    assign o_stall = i_full;

    // Pack operands per opcode; unused opcodes are taken and dropped
    always_comb begin
        known        = 1'b1;
        o_cmd.kind   = ssm_pkg::K_FRAME;
        o_cmd.fn     = i_frame_number;
        o_cmd.hl     = i_host_latency_tenths_ms;
        o_cmd.d0     = '0;
        o_cmd.d1     = '0;
        unique case (i_opcode)
            ssm_pkg::OP_FRAME: begin
                o_cmd.kind = ssm_pkg::K_FRAME;
                // negative byte counts count as zero
                o_cmd.d0   = i_byte_count[31] ? '0 : {9'b0, i_byte_count[30:0]};
                o_cmd.d1   = i_reassembly_us;
            end
            ssm_pkg::OP_DEC: begin
                o_cmd.kind = ssm_pkg::K_DEC;
                o_cmd.d0   = {8'b0, i_duration_us};
            end
            ssm_pkg::OP_PRES: begin
                o_cmd.kind = ssm_pkg::K_PRES;
                o_cmd.d0   = {8'b0, i_duration_us};
                o_cmd.d1   = i_queue_delay_us;
            end
            ssm_pkg::OP_DROP: begin
                o_cmd.kind = ssm_pkg::K_DROP;
            end
            ssm_pkg::OP_RTT: begin
                o_cmd.kind = ssm_pkg::K_RTT;
                o_cmd.d0   = {8'b0, i_rtt_ms};
                o_cmd.d1   = i_rtt_variance_ms;
            end
            ssm_pkg::OP_TICK: begin
                o_cmd.kind = ssm_pkg::K_TICK;
                o_cmd.d0   = i_now_ms;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && !i_full && known;

endmodule

// File: sv/ssm_queue.sv
// ssm_queue: short command queue between the front and the back.
// Depends on ssm_pkg.
module ssm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssm_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ssm_pkg::t_cmd  o_cmd
);

    ssm_pkg::t_cmd                  r_mem [ssm_pkg::Q_DEPTH];
    logic [ssm_pkg::QA_W-1:0]       r_wr;
    logic [ssm_pkg::QA_W-1:0]       r_rd;
    logic [ssm_pkg::QA_W:0]         r_cnt;

    assign o_full  = (r_cnt == (ssm_pkg::QA_W+1)'(ssm_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == ssm_pkg::QA_W'(ssm_pkg::Q_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == ssm_pkg::QA_W'(ssm_pkg::Q_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: sv/ssm_div.sv
// ssm_div: bit-serial restoring divider, one quotient bit per cycle,
// quotient saturated to the result width, zero for a zero divisor. Depends on ssm_pkg.
module ssm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ssm_pkg::NUM_W-1:0]     i_num,
    input  logic [ssm_pkg::DEN_W-1:0]     i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [ssm_pkg::VAL_W-1:0]     o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [ssm_pkg::CNT_W-1:0]     r_cnt;
    logic [ssm_pkg::NUM_W-1:0]     r_num;
    logic [ssm_pkg::NUM_W-1:0]     r_quo;
    logic [ssm_pkg::DEN_W-1:0]     r_den;
    logic [ssm_pkg::DEN_W-1:0]     r_rem;
    logic                          r_dz;
    logic [ssm_pkg::DEN_W:0]       shifted;
    logic                          fits;

    // One restoring step
    assign shifted = {r_rem, r_num[ssm_pkg::NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ssm_pkg::CNT_W'(ssm_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ssm_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_dz  <= (i_den == '0);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ssm_pkg::NUM_W-2:0], 1'b0};
            r_rem <= fits ? ssm_pkg::DEN_W'(shifted - {1'b0, r_den})
                          : shifted[ssm_pkg::DEN_W-1:0];
            r_quo <= {r_quo[ssm_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_dz ? '0 :
                    (|r_quo[ssm_pkg::NUM_W-1:ssm_pkg::VAL_W]) ? '1
                                                              : r_quo[ssm_pkg::VAL_W-1:0];

endmodule

// File: sv/ssm_back.sv
// ssm_back: applies queued events to the interval state and emits snapshots.
// Depends on ssm_pkg and ssm_div.
module ssm_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_write,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_q_valid,
    input  ssm_pkg::t_cmd              i_q_cmd,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [31:0]                o_sequence_res,
    output logic [39:0]                o_elapsed_ms,
    output logic [4:0]                 o_quantity,
    output logic [ssm_pkg::VAL_W-1:0]  o_value,
    output logic                       o_last
);

    ssm_pkg::t_state                 r_state, n_state;
    logic [ssm_pkg::ACCUM_W-1:0]     r_acc [ssm_pkg::N_ACC];
    logic [30:0]                     r_prev;
    logic                            r_prev_valid;
    logic [15:0]                     r_hl_min, r_hl_max;
    logic [31:0]                     r_rtt, r_rtt_var;
    logic [15:0]                     r_interval;
    logic [39:0]                     r_next_due, r_last_ms, r_now, r_e;
    logic [31:0]                     r_seq;
    logic [4:0]                      r_qty;
    logic [ssm_pkg::VAL_W-1:0]       r_val;

    logic                            r_ovalid, r_olast;
    logic [4:0]                      r_oqty;
    logic [ssm_pkg::VAL_W-1:0]       r_oval;
    logic [31:0]                     r_oseq;
    logic [39:0]                     r_onow;

    logic                            pop, div_start, out_load, fin, out_free, due;
    logic                            is_div;
    logic [ssm_pkg::OPA_W-1:0]       op_a;
    logic [ssm_pkg::OPB_W-1:0]       op_b;
    logic [ssm_pkg::DEN_W-1:0]       op_c;
    logic [ssm_pkg::VAL_W-1:0]       direct;
    logic [ssm_pkg::NUM_W-1:0]       prod;
    logic                            div_busy, div_done;
    logic [ssm_pkg::VAL_W-1:0]       div_quo;
    logic [31:0]                     prev_plus1;
    logic [40:0]                     due_sum;

    assign out_free   = !r_ovalid || !i_out_stall;
    assign due        = (i_q_cmd.d0 >= r_next_due);
    assign prev_plus1 = {1'b0, r_prev} + 32'd1;
    assign due_sum    = {1'b0, r_now} + 41'(r_interval);

    // Sequencer: next state and strobes
    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        fin       = 1'b0;
        unique case (r_state)
            ssm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    pop = 1'b1;
                    if (i_q_cmd.kind == ssm_pkg::K_TICK && due) begin
                        n_state = ssm_pkg::ST_OPER;
                    end
                end
            end
            ssm_pkg::ST_OPER: begin
                if (is_div) begin
                    div_start = 1'b1;
                    n_state   = ssm_pkg::ST_WAIT;
                end else begin
                    n_state = ssm_pkg::ST_PUT;
                end
            end
            ssm_pkg::ST_WAIT: begin
                if (div_done) begin
                    n_state = ssm_pkg::ST_PUT;
                end
            end
            ssm_pkg::ST_PUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = (r_qty == ssm_pkg::Q_RTT_VAR) ? ssm_pkg::ST_FIN
                                                             : ssm_pkg::ST_OPER;
                end
            end
            ssm_pkg::ST_FIN: begin
                fin     = 1'b1;
                n_state = ssm_pkg::ST_IDLE;
            end
            default: begin
                n_state = ssm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand select for the quantity being worked on
    always_comb begin
        is_div = 1'b1;
        op_a   = '0;
        op_b   = '0;
        op_c   = '0;
        direct = '0;
        unique case (r_qty)
            ssm_pkg::Q_FPS_TOTAL: begin
                op_a = {1'b0, r_acc[ssm_pkg::A_RX]} + {1'b0, r_acc[ssm_pkg::A_MISS]};
                op_b = ssm_pkg::OPB_W'(100000);
                op_c = ssm_pkg::DEN_W'(r_e);
            end
            ssm_pkg::Q_FPS_RX: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_RX]);
                op_b = ssm_pkg::OPB_W'(100000);
                op_c = ssm_pkg::DEN_W'(r_e);
            end
            ssm_pkg::Q_FPS_DEC: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_DEC]);
                op_b = ssm_pkg::OPB_W'(100000);
                op_c = ssm_pkg::DEN_W'(r_e);
            end
            ssm_pkg::Q_FPS_PRES: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_PRES]);
                op_b = ssm_pkg::OPB_W'(100000);
                op_c = ssm_pkg::DEN_W'(r_e);
            end
            ssm_pkg::Q_BITRATE: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_BYTES]);
                op_b = ssm_pkg::OPB_W'(8);
                op_c = ssm_pkg::DEN_W'(r_e) * ssm_pkg::DEN_W'(10);
            end
            ssm_pkg::Q_LOSS: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_MISS]);
                op_b = ssm_pkg::OPB_W'(10000);
                op_c = ssm_pkg::DEN_W'({1'b0, r_acc[ssm_pkg::A_RX]}
                                       + {1'b0, r_acc[ssm_pkg::A_MISS]});
            end
            ssm_pkg::Q_JITTER: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_DROPS]);
                op_b = ssm_pkg::OPB_W'(10000);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_DEC]);
            end
            ssm_pkg::Q_HL_MIN: begin
                is_div = 1'b0;
                direct = ssm_pkg::VAL_W'(r_hl_min) * ssm_pkg::VAL_W'(10);
            end
            ssm_pkg::Q_HL_MAX: begin
                is_div = 1'b0;
                direct = ssm_pkg::VAL_W'(r_hl_max) * ssm_pkg::VAL_W'(10);
            end
            ssm_pkg::Q_HL_AVG: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_HSUM]);
                op_b = ssm_pkg::OPB_W'(10);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_HCNT]);
            end
            ssm_pkg::Q_REASM: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_REASM]);
                op_b = ssm_pkg::OPB_W'(1);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_RX]) * ssm_pkg::DEN_W'(10);
            end
            ssm_pkg::Q_DECODE: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_DECUS]);
                op_b = ssm_pkg::OPB_W'(1);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_DEC]) * ssm_pkg::DEN_W'(10);
            end
            ssm_pkg::Q_PRESENT: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_PRESUS]);
                op_b = ssm_pkg::OPB_W'(1);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_PRES]) * ssm_pkg::DEN_W'(10);
            end
            ssm_pkg::Q_QDELAY: begin
                op_a = ssm_pkg::OPA_W'(r_acc[ssm_pkg::A_QDLY]);
                op_b = ssm_pkg::OPB_W'(1);
                op_c = ssm_pkg::DEN_W'(r_acc[ssm_pkg::A_PRES]) * ssm_pkg::DEN_W'(10);
            end
            ssm_pkg::Q_HAS_HL: begin
                is_div = 1'b0;
                direct = {{(ssm_pkg::VAL_W-1){1'b0}}, (r_acc[ssm_pkg::A_HCNT] != '0)};
            end
            ssm_pkg::Q_DROPS: begin
                is_div = 1'b0;
                direct = ssm_pkg::VAL_W'(r_acc[ssm_pkg::A_DROPS]);
            end
            ssm_pkg::Q_RTT: begin
                is_div = 1'b0;
                direct = ssm_pkg::VAL_W'(r_rtt) * ssm_pkg::VAL_W'(100);
            end
            ssm_pkg::Q_RTT_VAR: begin
                is_div = 1'b0;
                direct = ssm_pkg::VAL_W'(r_rtt_var) * ssm_pkg::VAL_W'(100);
            end
            default: begin
                is_div = 1'b0;
            end
        endcase
    end

    // Scaled dividend; the divider registers it on start
    assign prod = ssm_pkg::NUM_W'(op_a) * ssm_pkg::NUM_W'(op_b);

    ssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (op_c),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Interval state: event updates, snapshot bookkeeping, end-of-sample clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ssm_pkg::N_ACC; k++) begin
                r_acc[k] <= '0;
            end
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_hl_min     <= '0;
            r_hl_max     <= '0;
            r_rtt        <= '0;
            r_rtt_var    <= '0;
            r_interval   <= ssm_pkg::INTERVAL_RST;
            r_next_due   <= ssm_pkg::NEXT_DUE_RST;
            r_last_ms    <= '0;
            r_seq        <= '0;
            r_qty        <= '0;
        end else begin
            if (i_cfg_write) begin
                r_interval <= i_cfg_data;
            end
            if (fin) begin
                for (int k = 0; k < ssm_pkg::N_ACC; k++) begin
                    r_acc[k] <= '0;
                end
                r_hl_min   <= '0;
                r_hl_max   <= '0;
                r_last_ms  <= r_now;
                r_next_due <= due_sum[40] ? '1 : due_sum[39:0];
            end else if (pop) begin
                unique case (i_q_cmd.kind)
                    ssm_pkg::K_FRAME: begin
                        r_acc[ssm_pkg::A_RX] <= ssm_pkg::sat_add(r_acc[ssm_pkg::A_RX], 32'd1);
                        r_acc[ssm_pkg::A_BYTES] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_BYTES], i_q_cmd.d0[31:0]);
                        // gap in frame numbers counts as loss
                        if (r_prev_valid && {1'b0, i_q_cmd.fn} > prev_plus1) begin
                            r_acc[ssm_pkg::A_MISS] <= ssm_pkg::sat_add(
                                r_acc[ssm_pkg::A_MISS], {1'b0, i_q_cmd.fn} - prev_plus1);
                        end
                        r_prev       <= i_q_cmd.fn;
                        r_prev_valid <= 1'b1;
                        if (i_q_cmd.hl != '0) begin
                            r_acc[ssm_pkg::A_HSUM] <=
                                ssm_pkg::sat_add(r_acc[ssm_pkg::A_HSUM], 32'(i_q_cmd.hl));
                            r_acc[ssm_pkg::A_HCNT] <=
                                ssm_pkg::sat_add(r_acc[ssm_pkg::A_HCNT], 32'd1);
                            // zero min means none seen yet
                            if (r_hl_min == '0 || i_q_cmd.hl < r_hl_min) begin
                                r_hl_min <= i_q_cmd.hl;
                            end
                            if (i_q_cmd.hl > r_hl_max) begin
                                r_hl_max <= i_q_cmd.hl;
                            end
                        end
                        r_acc[ssm_pkg::A_REASM] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_REASM], i_q_cmd.d1);
                    end
                    ssm_pkg::K_DEC: begin
                        r_acc[ssm_pkg::A_DEC] <= ssm_pkg::sat_add(r_acc[ssm_pkg::A_DEC], 32'd1);
                        r_acc[ssm_pkg::A_DECUS] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_DECUS], i_q_cmd.d0[31:0]);
                    end
                    ssm_pkg::K_PRES: begin
                        r_acc[ssm_pkg::A_PRES] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_PRES], 32'd1);
                        r_acc[ssm_pkg::A_PRESUS] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_PRESUS], i_q_cmd.d0[31:0]);
                        r_acc[ssm_pkg::A_QDLY] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_QDLY], i_q_cmd.d1);
                    end
                    ssm_pkg::K_DROP: begin
                        r_acc[ssm_pkg::A_DROPS] <=
                            ssm_pkg::sat_add(r_acc[ssm_pkg::A_DROPS], 32'd1);
                    end
                    ssm_pkg::K_RTT: begin
                        r_rtt     <= i_q_cmd.d0[31:0];
                        r_rtt_var <= i_q_cmd.d1;
                    end
                    ssm_pkg::K_TICK: begin
                        if (due) begin
                            r_seq <= r_seq + 32'd1;
                            r_now <= i_q_cmd.d0;
                            // elapsed time floored at 1 ms
                            r_e   <= (i_q_cmd.d0 > r_last_ms) ? i_q_cmd.d0 - r_last_ms
                                                              : 40'd1;
                            r_qty <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (out_load && r_qty != ssm_pkg::Q_RTT_VAR) begin
                r_qty <= r_qty + 5'd1;
            end
        end
    end

    // Value of the current quantity
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::ST_OPER && !is_div) begin
            r_val <= direct;
        end else if (r_state == ssm_pkg::ST_WAIT && div_done) begin
            r_val <= div_quo;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oseq  <= r_seq;
            r_onow  <= r_now;
            r_oqty  <= r_qty;
            r_oval  <= r_val;
            r_olast <= (r_qty == ssm_pkg::Q_RTT_VAR);
        end
    end

    assign o_pop          = pop;
    assign o_out_valid    = r_ovalid;
    assign o_sequence_res = r_oseq;
    assign o_elapsed_ms   = r_onow;
    assign o_quantity     = r_oqty;
    assign o_value        = r_oval;
    assign o_last         = r_olast;

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_last_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_oqty == ssm_pkg::Q_RTT_VAR))
        else $error("last flag on wrong quantity");

    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> (r_ovalid && r_olast))
        else $error("sample closed before last beat was loaded");
`endif

endmodule

// File: sv/stream_statistics_monitor.sv
// stream_statistics_monitor: top level of the stream statistics monitor.
// Depends on ssm_pkg, ssm_front, ssm_queue and ssm_back.

// Events enter through a two-entry command queue, so the input is stalled
// only while the queue is full. Frame, decode, present, drop and RTT events
// are applied as the idle sequencer pops them. A due sample tick emits 18
// beats, one per quantity in snapshot order, with last set on the final one.
// Twelve of them go through one shared bit-serial divider at one quotient
// bit per cycle (66 quotient bits) and pass the operand, wait and put
// states; the other six pass the operand and put states only. Later events
// wait in the queue while a snapshot is emitted. Values are hundredths,
// truncated, saturating at 48 bits, apart from the latency flag and the
// drop count. The interval register is taken whenever written (ready is
// always high) and affects only the schedule after the next snapshot.
module stream_statistics_monitor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_opcode,
    input  logic [30:0]                i_frame_number,
    input  logic signed [31:0]         i_byte_count,
    input  logic [15:0]                i_host_latency_tenths_ms,
    input  logic [31:0]                i_reassembly_us,
    input  logic [31:0]                i_duration_us,
    input  logic [31:0]                i_queue_delay_us,
    input  logic [31:0]                i_rtt_ms,
    input  logic [31:0]                i_rtt_variance_ms,
    input  logic [39:0]                i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [31:0]                o_sequence_res,
    output logic [39:0]                o_elapsed_ms,
    output logic [4:0]                 o_quantity,
    output logic [47:0]                o_value,
    output logic                       o_last
);

    logic           push, pop, q_full, q_valid;
    ssm_pkg::t_cmd  f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    ssm_front u_front (
        .i_valid                  (i_in_valid),
        .i_full                   (q_full),
        .i_opcode                 (i_opcode),
        .i_frame_number           (i_frame_number),
        .i_byte_count             (i_byte_count),
        .i_host_latency_tenths_ms (i_host_latency_tenths_ms),
        .i_reassembly_us          (i_reassembly_us),
        .i_duration_us            (i_duration_us),
        .i_queue_delay_us         (i_queue_delay_us),
        .i_rtt_ms                 (i_rtt_ms),
        .i_rtt_variance_ms        (i_rtt_variance_ms),
        .i_now_ms                 (i_now_ms),
        .o_stall                  (o_in_stall),
        .o_push                   (push),
        .o_cmd                    (f_cmd)
    );

    ssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ssm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sequence_res (o_sequence_res),
        .o_elapsed_ms   (o_elapsed_ms),
        .o_quantity     (o_quantity),
        .o_value        (o_value),
        .o_last         (o_last)
    );

endmodule
